### design/b64c_pkg.sv
// Shared types and codes for the base64 codec.
package b64c_pkg;

   // Job codes passed from the front end to the back end
   localparam logic [1:0] OP_ENC  = 2'd0;  // four characters from a 24-bit group
   localparam logic [1:0] OP_BYTE = 2'd1;  // one decoded byte
   localparam logic [1:0] OP_END  = 2'd2;  // end marker without data
   localparam logic [1:0] OP_ERR  = 2'd3;  // invalid character

   // Result kinds
   localparam logic [1:0] KIND_DATA = 2'd0;
   localparam logic [1:0] KIND_END  = 2'd1;
   localparam logic [1:0] KIND_ERR  = 2'd2;

   // Codec modes
   localparam logic MODE_ENCODE = 1'b0;
   localparam logic MODE_DECODE = 1'b1;

   localparam logic [7:0] CHAR_PAD = 8'h3D;

   // Job queue between front and back end
   localparam int JOB_DEPTH = 4;
   localparam int JOB_AW    = $clog2(JOB_DEPTH);

   // Config register map (byte address bit that selects the register)
   localparam logic REG_MODE = 1'b0;

   typedef struct packed {
      logic [1:0]  op;
      logic [23:0] data;  // group for OP_ENC, byte in [7:0] for OP_BYTE
      logic [1:0]  pad;   // number of '=' at the end of an OP_ENC group
      logic        last;
   } job_type;

endpackage

### design/b64c_front.sv
// Front end: takes input items, keeps the per-mode state and issues jobs.
module b64c_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             mode,
   input  logic             req_push,
   input  logic [7:0]       req_in_value,
   input  logic             req_in_last,
   output logic             req_full,
   input  logic             job_full,
   output logic             job_push,
   output b64c_pkg::job_type job
);
   import b64c_pkg::*;

   logic [15:0] held_bytes_ff, held_bytes_in;
   logic [1:0]  held_count_ff, held_count_in;
   logic [5:0]  bit_acc_ff, bit_acc_in;
   logic [2:0]  bit_count_ff, bit_count_in;
   logic        pad_seen_ff, pad_seen_in;
   logic        skip_rest_ff, skip_rest_in;

   logic        accept;
   logic        job_valid;
   logic [6:0]  dec;
   logic [11:0] acc;

   // bit 6 set when the character belongs to the alphabet
   function automatic logic [6:0] char_decode(input logic [7:0] c);
      logic [7:0] v;
      v = 8'd0;
      priority if (c >= 8'h41 && c <= 8'h5A) begin
         v = c - 8'h41;
      end else if (c >= 8'h61 && c <= 8'h7A) begin
         v = c - 8'h61 + 8'd26;
      end else if (c >= 8'h30 && c <= 8'h39) begin
         v = c - 8'h30 + 8'd52;
      end else if (c == 8'h2B) begin
         v = 8'd62;
      end else if (c == 8'h2F) begin
         v = 8'd63;
      end else begin
         return 7'd0;
      end
      return {1'b1, v[5:0]};
   endfunction

   assign req_full = job_full;
   assign accept   = req_push && !job_full;
   assign job_push = accept && job_valid;
   assign dec      = char_decode(req_in_value);
   assign acc      = {bit_acc_ff, dec[5:0]};

   always_comb begin
      held_bytes_in = held_bytes_ff;
      held_count_in = held_count_ff;
      bit_acc_in    = bit_acc_ff;
      bit_count_in  = bit_count_ff;
      pad_seen_in   = pad_seen_ff;
      skip_rest_in  = skip_rest_ff;
      job_valid     = 1'b0;
      job           = '0;
      job.last      = req_in_last;
      if (mode == MODE_ENCODE) begin
         job.op = OP_ENC;
         if (held_count_ff == 2'd2) begin
            job_valid     = 1'b1;
            job.data      = {held_bytes_ff, req_in_value};
            held_bytes_in = '0;
            held_count_in = '0;
         end else begin
            held_bytes_in = {held_bytes_ff[7:0], req_in_value};
            held_count_in = held_count_ff + 2'd1;
            if (req_in_last) begin
               job_valid = 1'b1;
               if (held_count_ff == 2'd0) begin
                  job.data = {req_in_value, 16'd0};
                  job.pad  = 2'd2;
               end else begin
                  job.data = {held_bytes_ff[7:0], req_in_value, 8'd0};
                  job.pad  = 2'd1;
               end
               held_bytes_in = '0;
               held_count_in = '0;
            end
         end
      end else begin
         if (skip_rest_ff) begin
            if (req_in_last) begin
               skip_rest_in = 1'b0;
               pad_seen_in  = 1'b0;
               bit_acc_in   = '0;
               bit_count_in = '0;
            end
         end else begin
            if (!pad_seen_ff) begin
               if (req_in_value == CHAR_PAD) begin
                  pad_seen_in = 1'b1;
               end else if (!dec[6]) begin
                  job_valid = 1'b1;
                  job.op    = OP_ERR;
                  job.last  = 1'b1;
                  if (!req_in_last) begin
                     skip_rest_in = 1'b1;
                  end
               end else begin
                  unique case (bit_count_ff)
                     3'd2: begin
                        job_valid    = 1'b1;
                        job.op       = OP_BYTE;
                        job.data     = {16'd0, acc[7:0]};
                        bit_acc_in   = '0;
                        bit_count_in = 3'd0;
                     end
                     3'd4: begin
                        job_valid    = 1'b1;
                        job.op       = OP_BYTE;
                        job.data     = {16'd0, acc[9:2]};
                        bit_acc_in   = {4'd0, acc[1:0]};
                        bit_count_in = 3'd2;
                     end
                     3'd6: begin
                        job_valid    = 1'b1;
                        job.op       = OP_BYTE;
                        job.data     = {16'd0, acc[11:4]};
                        bit_acc_in   = {2'd0, acc[3:0]};
                        bit_count_in = 3'd4;
                     end
                     default: begin
                        bit_acc_in   = dec[5:0];
                        bit_count_in = 3'd6;
                     end
                  endcase
               end
            end
            if (req_in_last) begin
               if (!job_valid) begin
                  job_valid = 1'b1;
                  job.op    = OP_END;
                  job.last  = 1'b1;
               end
               skip_rest_in = 1'b0;
               pad_seen_in  = 1'b0;
               bit_acc_in   = '0;
               bit_count_in = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_bytes_ff <= '0;
         held_count_ff <= '0;
         bit_acc_ff    <= '0;
         bit_count_ff  <= '0;
         pad_seen_ff   <= 1'b0;
         skip_rest_ff  <= 1'b0;
      end else if (accept) begin
         held_bytes_ff <= held_bytes_in;
         held_count_ff <= held_count_in;
         bit_acc_ff    <= bit_acc_in;
         bit_count_ff  <= bit_count_in;
         pad_seen_ff   <= pad_seen_in;
         skip_rest_ff  <= skip_rest_in;
      end
   end

endmodule

### design/b64c_fifo.sv
// Short job queue between the front and back end.
module b64c_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  b64c_pkg::job_type push_job,
   output logic             full,
   input  logic             pop,
   output b64c_pkg::job_type pop_job,
   output logic             empty
);
   import b64c_pkg::*;

   job_type             slot_ff [JOB_DEPTH];
   logic [JOB_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [JOB_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [JOB_AW:0]     count_ff, count_in;
   logic                do_push, do_pop;

   assign full    = (count_ff == (JOB_AW+1)'(JOB_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign pop_job = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("job pushed into full queue");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (JOB_AW+1)'(JOB_DEPTH))
      else $error("job count out of range");

   a_ptr_track: assert property (@(posedge clock) disable iff (reset)
      (wr_ptr_ff - rd_ptr_ff) == count_ff[JOB_AW-1:0])
      else $error("queue pointers disagree with count");

endmodule

### design/b64c_back.sv
// Back end: expands jobs into result transactions, one per cycle while the receiver pops.
module b64c_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             job_empty,
   input  b64c_pkg::job_type job,
   output logic             job_pop,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output logic [7:0]       rsp_out_value,
   output logic [1:0]       rsp_out_kind,
   output logic             rsp_out_last
);
   import b64c_pkg::*;

   job_type    cur_ff;
   logic       cur_valid_ff, cur_valid_in;
   logic [1:0] idx_ff, idx_in;
   logic       at_end;
   logic       load;
   logic [5:0] sextet;
   logic       is_pad;

   function automatic logic [7:0] alpha(input logic [5:0] v);
      logic [7:0] w;
      w = {2'd0, v};
      priority if (v < 6'd26) begin
         return w + 8'h41;
      end else if (v < 6'd52) begin
         return w - 8'd26 + 8'h61;
      end else if (v < 6'd62) begin
         return w - 8'd52 + 8'h30;
      end else if (v == 6'd62) begin
         return 8'h2B;
      end else begin
         return 8'h2F;
      end
   endfunction

   assign rsp_empty = !cur_valid_ff;
   assign at_end    = (cur_ff.op != OP_ENC) || (idx_ff == 2'd3);
   // refill when idle or when the final result of the current job leaves
   assign load      = !cur_valid_ff || (rsp_pop && at_end);
   assign job_pop   = load && !job_empty;

   always_comb begin
      cur_valid_in = cur_valid_ff;
      idx_in       = idx_ff;
      if (load) begin
         cur_valid_in = !job_empty;
         idx_in       = '0;
      end else if (rsp_pop) begin
         idx_in = idx_ff + 2'd1;
      end
   end

   always_comb begin
      unique case (idx_ff)
         2'd0: sextet = cur_ff.data[23:18];
         2'd1: sextet = cur_ff.data[17:12];
         2'd2: sextet = cur_ff.data[11:6];
         2'd3: sextet = cur_ff.data[5:0];
         default: sextet = '0;
      endcase
      is_pad = ((idx_ff == 2'd3) && (cur_ff.pad != 2'd0))
            || ((idx_ff == 2'd2) && (cur_ff.pad == 2'd2));
   end

   always_comb begin
      unique case (cur_ff.op)
         OP_ENC: begin
            rsp_out_value = is_pad ? CHAR_PAD : alpha(sextet);
            rsp_out_kind  = KIND_DATA;
            rsp_out_last  = cur_ff.last && (idx_ff == 2'd3);
         end
         OP_BYTE: begin
            rsp_out_value = cur_ff.data[7:0];
            rsp_out_kind  = KIND_DATA;
            rsp_out_last  = cur_ff.last;
         end
         OP_END: begin
            rsp_out_value = 8'd0;
            rsp_out_kind  = KIND_END;
            rsp_out_last  = 1'b1;
         end
         OP_ERR: begin
            rsp_out_value = 8'd0;
            rsp_out_kind  = KIND_ERR;
            rsp_out_last  = 1'b1;
         end
         default: begin
            rsp_out_value = 8'd0;
            rsp_out_kind  = KIND_DATA;
            rsp_out_last  = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (job_pop) begin
         cur_ff <= job;
      end
   end

   a_single_idx: assert property (@(posedge clock) disable iff (reset)
      (cur_valid_ff && cur_ff.op != OP_ENC) |-> idx_ff == 2'd0)
      else $error("single-result job advanced past first transaction");

   a_hold_stall: assert property (@(posedge clock) disable iff (reset)
      (cur_valid_ff && !rsp_pop) |=> (cur_valid_ff && $stable(idx_ff)))
      else $error("result changed while stalled");

endmodule

### design/base64_codec_top.sv
// Top level of the streaming base64 codec with its configuration port.
// Base64 codec (standard alphabet). csr register 0 at byte address 0 holds the mode:
// 0 encodes bytes to characters, 1 decodes characters to bytes; each mode keeps its own
// partial state across mode changes. The user must change the mode only while the codec is idle;
// the block itself does not enforce it. The front end takes one input item every cycle while its
// four-entry job queue has room; the back end delivers one result transaction per cycle while
// the receiver pops. Throughput is set by that single result port: encoding produces four
// characters per three bytes, so a steady byte stream is limited by the characters, while
// decoding runs at one character per cycle while the receiver keeps up. An input item is answered
// only after it has passed through the job queue and the back end's current-job register.
module base64_codec_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_in_value,
   input  logic        req_in_last,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [7:0]  rsp_out_value,
   output logic [1:0]  rsp_out_kind,
   output logic        rsp_out_last,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import b64c_pkg::*;

   logic    mode_ff;
   logic    job_push, job_full, job_pop, job_empty;
   job_type front_job, back_job;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_MODE) ? {31'd0, mode_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_ENCODE;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready
                   && csr_paddr[2] == REG_MODE) begin
         mode_ff <= csr_pwdata[0];
      end
   end

   b64c_front u_front (
      .clock        (clock),
      .reset        (reset),
      .mode         (mode_ff),
      .req_push     (req_push),
      .req_in_value (req_in_value),
      .req_in_last  (req_in_last),
      .req_full     (req_full),
      .job_full     (job_full),
      .job_push     (job_push),
      .job          (front_job)
   );

   b64c_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .push_job (front_job),
      .full     (job_full),
      .pop      (job_pop),
      .pop_job  (back_job),
      .empty    (job_empty)
   );

   b64c_back u_back (
      .clock         (clock),
      .reset         (reset),
      .job_empty     (job_empty),
      .job           (back_job),
      .job_pop       (job_pop),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_out_value (rsp_out_value),
      .rsp_out_kind  (rsp_out_kind),
      .rsp_out_last  (rsp_out_last)
   );

endmodule

### bench/base64_codec_checker.sv
// Watches the base64 codec channels, predicts every result and compares.
`timescale 1ns / 1ps

module base64_codec_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   input  logic        req_full,
   input  logic [7:0]  req_in_value,
   input  logic        req_in_last,
   input  logic        rsp_empty,
   input  logic        rsp_pop,
   input  logic [7:0]  rsp_out_value,
   input  logic [1:0]  rsp_out_kind,
   input  logic        rsp_out_last,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic [31:0] csr_prdata,
   input  logic        csr_pready,
   output int          mismatches,
   output int          pending,
   output int          items_taken,
   output int          results_seen
);
   import b64c_pkg::*;

   typedef struct packed {
      logic [7:0] value;
      logic [1:0] kind;
      logic       last;
   } codec_result_type;

   codec_result_type codec_results[$];
   codec_result_type want;

   logic        mode;
   // encoder side
   logic [15:0] enc_held;
   logic [1:0]  enc_count;
   // decoder side
   logic [5:0]  dec_acc;
   logic [2:0]  dec_bits;
   logic        dec_pad;
   logic        dec_skip;

   function automatic logic [7:0] sextet_char(input logic [5:0] s);
      if (s < 26) return "A" + s;
      if (s < 52) return 8'("a" + (s - 26));
      if (s < 62) return 8'("0" + (s - 52));
      if (s == 62) return "+";
      return "/";
   endfunction

   function automatic int char_sextet(input logic [7:0] c);
      if (c >= "A" && c <= "Z") return c - "A";
      if (c >= "a" && c <= "z") return c - "a" + 26;
      if (c >= "0" && c <= "9") return c - "0" + 52;
      if (c == "+") return 62;
      if (c == "/") return 63;
      return -1;
   endfunction

   function automatic void add_result(input logic [7:0] v, input logic [1:0] k, input logic l);
      codec_result_type r;
      r.value = v;
      r.kind  = k;
      r.last  = l;
      codec_results.insert(codec_results.size(), r);
   endfunction

   function automatic void flag_error(input string msg);
      mismatches++;
      if (mismatches <= 10) $display("%s", msg);
   endfunction

   function automatic void clear_decoder();
      dec_acc  = '0;
      dec_bits = '0;
      dec_pad  = 1'b0;
      dec_skip = 1'b0;
   endfunction

   function automatic void encode_step(input logic [7:0] b, input logic l);
      logic [23:0] grp;
      if (enc_count == 2'd2) begin
         grp = {enc_held, b};
         add_result(sextet_char(grp[23:18]), KIND_DATA, 1'b0);
         add_result(sextet_char(grp[17:12]), KIND_DATA, 1'b0);
         add_result(sextet_char(grp[11:6]), KIND_DATA, 1'b0);
         add_result(sextet_char(grp[5:0]), KIND_DATA, l);
         enc_held  = '0;
         enc_count = '0;
      end else begin
         enc_held  = {enc_held[7:0], b};
         enc_count = enc_count + 2'd1;
         if (l) begin
            // short group at message end: one byte gets two pads, two bytes get one
            grp = (enc_count == 2'd1) ? {enc_held[7:0], 16'h0} : {enc_held, 8'h0};
            add_result(sextet_char(grp[23:18]), KIND_DATA, 1'b0);
            add_result(sextet_char(grp[17:12]), KIND_DATA, 1'b0);
            add_result((enc_count == 2'd1) ? CHAR_PAD : sextet_char(grp[11:6]),
                       KIND_DATA, 1'b0);
            add_result(CHAR_PAD, KIND_DATA, 1'b1);
            enc_held  = '0;
            enc_count = '0;
         end
      end
   endfunction

   function automatic void decode_step(input logic [7:0] c, input logic l);
      int          sx;
      int          bits;
      logic [11:0] acc;
      logic        made;
      made = 1'b0;
      if (dec_skip) begin
         if (l) clear_decoder();
         return;
      end
      if (!dec_pad) begin
         if (c == CHAR_PAD) begin
            dec_pad = 1'b1;
         end else begin
            sx = char_sextet(c);
            if (sx < 0) begin
               add_result(8'h00, KIND_ERR, 1'b1);
               if (l) clear_decoder();
               else dec_skip = 1'b1;
               return;
            end
            acc  = {dec_acc, sx[5:0]};
            bits = dec_bits + 6;
            if (bits >= 8) begin
               bits -= 8;
               add_result(8'(acc >> bits), KIND_DATA, l);
               made = 1'b1;
            end
            dec_acc  = 6'(acc & ((12'd1 << bits) - 1));
            dec_bits = 3'(bits);
         end
      end
      if (l) begin
         if (!made) add_result(8'h00, KIND_END, 1'b1);
         clear_decoder();
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         codec_results.delete();
         mode         = MODE_ENCODE;
         enc_held     = '0;
         enc_count    = '0;
         clear_decoder();
         mismatches   = 0;
         items_taken  = 0;
         results_seen = 0;
      end else begin
         // result side first, so a result never matches an item taken at the same edge
         if (rsp_pop && !rsp_empty) begin
            results_seen++;
            if (codec_results.size() == 0) begin
               flag_error($sformatf("unexpected result: value %02h kind %0d last %0b",
                                    rsp_out_value, rsp_out_kind, rsp_out_last));
            end else begin
               want = codec_results.pop_front();
               if (want.value !== rsp_out_value || want.kind !== rsp_out_kind ||
                   want.last !== rsp_out_last)
                  flag_error($sformatf(
                     "result %0d: expected value %02h kind %0d last %0b, got %02h %0d %0b",
                     results_seen, want.value, want.kind, want.last,
                     rsp_out_value, rsp_out_kind, rsp_out_last));
            end
         end
         if (csr_psel && csr_penable && csr_pready && !csr_pwrite &&
             csr_paddr[2] == REG_MODE && csr_prdata !== {31'b0, mode})
            flag_error($sformatf("mode read: expected %08h, got %08h",
                                 {31'b0, mode}, csr_prdata));
         if (req_push && !req_full) begin
            items_taken++;
            if (mode == MODE_DECODE) decode_step(req_in_value, req_in_last);
            else encode_step(req_in_value, req_in_last);
         end
         if (csr_psel && csr_penable && csr_pready && csr_pwrite &&
             csr_paddr[2] == REG_MODE)
            mode = csr_pwdata[0];
      end
      pending = codec_results.size();
   end

endmodule

### bench/base64_codec_top_tb.sv
// Stimulus and verdict for the base64 codec, with the checker beside the block.
`timescale 1ns / 1ps

module base64_codec_top_tb;
   import b64c_pkg::*;

   localparam logic [2:0] ADDR_MODE  = 3'd0;
   localparam logic [2:0] ADDR_SPARE = 3'd4;  // no register here
   localparam int SETTLE       = 16;
   localparam int HOLD_CYCLES  = 80;
   localparam int CYCLE_LIMIT  = 400000;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_push;
   logic        req_full;
   logic [7:0]  req_in_value;
   logic        req_in_last;
   logic        rsp_empty;
   logic        rsp_pop;
   logic [7:0]  rsp_out_value;
   logic [1:0]  rsp_out_kind;
   logic        rsp_out_last;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int    mismatches;
   int    pending;
   int    items_taken;
   int    results_seen;
   int    cycle_count = 0;
   int    mode_changes;
   int    hold_ticket;
   logic  no_idle;
   logic  mode_now;
   string b64_alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

   always #5 clock = ~clock;

   base64_codec_top u_top (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_in_value  (req_in_value),
      .req_in_last   (req_in_last),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_out_value (rsp_out_value),
      .rsp_out_kind  (rsp_out_kind),
      .rsp_out_last  (rsp_out_last),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready)
   );

   base64_codec_checker u_check (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_in_value  (req_in_value),
      .req_in_last   (req_in_last),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_out_value (rsp_out_value),
      .rsp_out_kind  (rsp_out_kind),
      .rsp_out_last  (rsp_out_last),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready),
      .mismatches    (mismatches),
      .pending       (pending),
      .items_taken   (items_taken),
      .results_seen  (results_seen)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
         $display("base64_codec_top: mismatch");
         $finish;
      end
   end

   function automatic int pick_gap();
      int r;
      if (no_idle) return 0;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 30);
   endfunction

   // mostly alphabet characters, some pads, some arbitrary codes
   function automatic logic [7:0] pick_char();
      int r;
      r = $urandom_range(0, 99);
      if (r < 85) return b64_alphabet[$urandom_range(0, 63)];
      if (r < 91) return CHAR_PAD;
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic offer_item(input logic [7:0] v, input logic l, input int gap);
      int g;
      for (g = 0; g < gap; g++) begin
         @(negedge clock);
         req_push <= 1'b0;
      end
      @(negedge clock);
      req_push     <= 1'b1;
      req_in_value <= v;
      req_in_last  <= l;
      do @(posedge clock); while (req_full);
   endtask

   task automatic send_text(input string s);
      int i;
      for (i = 0; i < s.len(); i++)
         offer_item(s[i], i == s.len() - 1, pick_gap());
   endtask

   // messages of random length; the last one may be left open
   task automatic send_messages(input int count);
      int left;
      int len;
      int i;
      left = count;
      while (left > 0) begin
         len = $urandom_range(1, 12);
         for (i = 0; i < len && left > 0; i++) begin
            offer_item((mode_now == MODE_DECODE) ? pick_char() : 8'($urandom_range(0, 255)),
                       i == len - 1, pick_gap());
            left--;
         end
      end
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_push <= 1'b0;
      while (pending != 0) @(negedge clock);
      // a byte that produces nothing may still be in flight
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic csr_access(input logic wr, input logic [2:0] a, input logic [31:0] d);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= a;
      csr_pwdata  <= d;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic set_mode(input logic m);
      logic [31:0] d;
      wait_idle();
      d    = $urandom;
      d[0] = m;
      csr_access(1'b1, ADDR_MODE, d);
      csr_access(1'b0, ADDR_MODE, 32'h0);
      mode_now = m;
      mode_changes++;
   endtask

   // receiver: random pop gaps, plus a long hold-off on request
   initial begin
      int stall_left;
      int hold_done;
      int r;
      stall_left = 0;
      hold_done  = 0;
      rsp_pop    = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_ticket != hold_done) begin
            hold_done  = hold_ticket;
            stall_left = HOLD_CYCLES;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
            if (!no_idle) begin
               r = $urandom_range(0, 99);
               if (r < 20) stall_left = $urandom_range(1, 3);
               else if (r < 23) stall_left = $urandom_range(10, 30);
            end
         end
      end
   end

   initial begin
      reset        = 1'b1;
      req_push     = 1'b0;
      req_in_value = 8'h00;
      req_in_last  = 1'b0;
      csr_psel     = 1'b0;
      csr_penable  = 1'b0;
      csr_pwrite   = 1'b0;
      csr_paddr    = ADDR_MODE;
      csr_pwdata   = 32'h0;
      no_idle      = 1'b0;
      hold_ticket  = 0;
      mode_changes = 0;
      mode_now     = MODE_ENCODE;
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      csr_access(1'b0, ADDR_MODE, 32'h0);

      // full group, short groups with two and one pad, group plus tail
      offer_item(8'h4D, 1'b0, pick_gap());
      offer_item(8'h61, 1'b0, pick_gap());
      offer_item(8'h6E, 1'b1, pick_gap());
      offer_item(8'h00, 1'b1, pick_gap());
      offer_item(8'hFF, 1'b0, pick_gap());
      offer_item(8'hFF, 1'b1, pick_gap());
      offer_item(8'hFB, 1'b0, pick_gap());
      offer_item(8'hFF, 1'b0, pick_gap());
      offer_item(8'hBF, 1'b0, pick_gap());
      offer_item(8'h80, 1'b1, pick_gap());
      // write to an unmapped address must not change the mode
      wait_idle();
      csr_access(1'b1, ADDR_SPARE, 32'hFFFF_FFFF);
      // open an encode message, then decode in between
      offer_item(8'hAB, 1'b0, pick_gap());
      set_mode(MODE_DECODE);
      send_text("QQ=");     // byte, then pad at the end gives an end marker
      send_text("*AB");     // invalid character, rest of message skipped
      offer_item(8'hFF, 1'b1, pick_gap());
      send_text("=");
      send_text("+/9z");
      set_mode(MODE_ENCODE);
      offer_item(8'hCD, 1'b0, pick_gap());
      offer_item(8'hEF, 1'b1, pick_gap());

      send_messages(45);
      set_mode(MODE_DECODE);
      send_messages(55);
      set_mode(MODE_ENCODE);
      // receiver holds off while bytes keep coming back to back
      @(posedge clock);
      no_idle = 1'b1;
      hold_ticket++;
      send_messages(30);
      set_mode(MODE_DECODE);
      send_messages(40);
      @(posedge clock);
      no_idle = 1'b0;
      set_mode(MODE_ENCODE);
      send_messages(35);
      set_mode(MODE_DECODE);
      send_messages(45);
      wait_idle();

      $display("ran %0d items into %0d results across %0d mode changes",
               items_taken, results_seen, mode_changes);
      $display("covered padding, invalid characters, open messages across mode switches, "
               , "and a long output stall");
      if (mismatches == 0 && pending == 0)
         $display("base64_codec_top: match");
      else
         $display("base64_codec_top: mismatch");
      $finish;
   end

endmodule
